/* rtl/core/sspq_pkg.sv */
// Shared types and codes for the stable sorted priority queue.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package sspq_pkg;

    // Operation codes carried in the input tuser bit.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Controller states: no result held, or a result waiting on the output.
    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;      // an input word is accepted this cycle
        logic result_out; // the result register is presented downstream
    } ctl_cmd_t;

endpackage

/* rtl/core/sspq_ctrl.sv */
// Handshake controller of the stable sorted priority queue.
// Depends on sspq_pkg for the state type and the command struct.
`timescale 1ns / 1ps

module sspq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sspq_pkg::ctl_cmd_t cmd
);

    sspq_pkg::ctl_state_t state_reg;
    sspq_pkg::ctl_state_t state_next;
    logic                 accept;

    assign accept = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sspq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a new word refills the result register even as the old one leaves.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sspq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sspq_pkg::ST_HOLD;
                end
            end
            sspq_pkg::ST_HOLD:
            begin
                if (!accept && m_tready)
                begin
                    state_next = sspq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sspq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: the input is open whenever the result register is empty or draining.
    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        case (state_reg)
            sspq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            sspq_pkg::ST_HOLD:
            begin
                s_tready = m_tready;
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.apply      = s_tvalid && s_tready;
        cmd.result_out = m_tvalid;
    end

endmodule

/* rtl/core/sspq_datapath.sv */
// Datapath of the stable sorted priority queue: a row of entry cells with
// per-cell compare and shift, the entry count and the result register.
// Depends on sspq_pkg for the command struct and operation codes.
`timescale 1ns / 1ps

module sspq_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 8,
    parameter int CNT_W         = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sspq_pkg::ctl_cmd_t       cmd,
    input  logic                     command,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    input  logic [TAG_BITS-1:0]      tag,
    output logic                     valid_res,
    output logic [PRIORITY_BITS-1:0] head_priority,
    output logic [TAG_BITS-1:0]      head_tag,
    output logic [CNT_W-1:0]         occupancy,
    output logic                     dropped
);

    // Entry cells, head at index 0; contents only meaningful below the count.
    logic [PRIORITY_BITS-1:0] prio_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      tag_reg  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] prio_next [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      tag_next  [QUEUE_DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // Result register.
    logic                     res_valid_reg;
    logic [PRIORITY_BITS-1:0] res_prio_reg;
    logic [TAG_BITS-1:0]      res_tag_reg;
    logic [CNT_W-1:0]         res_count_reg;
    logic                     res_drop_reg;

    logic [QUEUE_DEPTH-1:0]   keep;
    logic                     full;
    logic                     empty;
    logic                     reject;
    logic                     is_push;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign is_push = (command == sspq_pkg::CMD_PUSH);
    // A full queue turns the push away when its last entry is not outranked.
    assign reject  = full && keep[QUEUE_DEPTH-1];

    // Per cell: a held entry stays in place when it ranks at or above the new one.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            assign keep[gi] = (count_reg > CNT_W'(gi)) && (prio_reg[gi] >= priority_req);

            always_comb
            begin
                prio_next[gi] = prio_reg[gi];
                tag_next[gi]  = tag_reg[gi];
                if (is_push)
                begin
                    if (!reject && !keep[gi])
                    begin
                        if (gi == 0)
                        begin
                            prio_next[gi] = priority_req;
                            tag_next[gi]  = tag;
                        end
                        else if (keep[(gi > 0) ? gi - 1 : 0])
                        begin
                            prio_next[gi] = priority_req;
                            tag_next[gi]  = tag;
                        end
                        else
                        begin
                            prio_next[gi] = prio_reg[(gi > 0) ? gi - 1 : 0];
                            tag_next[gi]  = tag_reg[(gi > 0) ? gi - 1 : 0];
                        end
                    end
                end
                else if (gi < QUEUE_DEPTH - 1)
                begin
                    // Pop moves every entry one cell toward the head.
                    prio_next[gi] = prio_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                    tag_next[gi]  = tag_reg[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.apply)
                begin
                    prio_reg[gi] <= prio_next[gi];
                    tag_reg[gi]  <= tag_next[gi];
                end
            end
        end
    endgenerate

    // Entry count after the operation.
    always_comb
    begin
        count_next = count_reg;
        if (is_push)
        begin
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (!empty)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    // Result capture: new head after a push, old head on a pop, zeros on an empty pop.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            res_count_reg <= count_next;
            res_drop_reg  <= is_push && full;
            if (is_push)
            begin
                res_valid_reg <= 1'b1;
                res_prio_reg  <= prio_next[0];
                res_tag_reg   <= tag_next[0];
            end
            else if (!empty)
            begin
                res_valid_reg <= 1'b1;
                res_prio_reg  <= prio_reg[0];
                res_tag_reg   <= tag_reg[0];
            end
            else
            begin
                res_valid_reg <= 1'b0;
                res_prio_reg  <= '0;
                res_tag_reg   <= '0;
            end
        end
    end

    // Outputs are zero while nothing is presented, which keeps the bus quiet.
    assign valid_res     = cmd.result_out ? res_valid_reg : 1'b0;
    assign head_priority = cmd.result_out ? res_prio_reg : '0;
    assign head_tag      = cmd.result_out ? res_tag_reg : '0;
    assign occupancy     = cmd.result_out ? res_count_reg : '0;
    assign dropped       = cmd.result_out ? res_drop_reg : 1'b0;

endmodule

/* rtl/core/stable_sorted_priority_queue_core.sv */
// Top level of the stable sorted priority queue.
// Instantiates sspq_ctrl and sspq_datapath; uses sspq_pkg.
//
//  Channel | Direction | Payload
//  --------+-----------+-------------------------------------------------
//  s_*     | in        | tuser: command; tdata: priority_req, tag
//  m_*     | out       | tuser: valid_res; tdata: head_priority, head_tag,
//          |           |        occupancy, dropped
//
// The compare and shift across all cells and the result capture happen at the
// accepting edge, and the result shows on the output in the next cycle. The
// single result register sets the rate: one word per cycle while the output
// drains, and the input stalls only while a result waits and m_tready is low.
// Reset empties the queue at once; no clearing pass is run.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // [PRIORITY_BITS-1:0] priority_req, then tag, zero padded to bytes
    input  logic [((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] command
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // head_priority, head_tag, occupancy, dropped from bit 0 up, zero padded
    output logic [((PRIORITY_BITS + TAG_BITS + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0]
                 m_tdata,
    // [0] valid_res
    output logic m_tuser
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W  = PRIORITY_BITS + TAG_BITS + CNT_W + 1;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    sspq_pkg::ctl_cmd_t       cmd;
    logic                     valid_res;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [TAG_BITS-1:0]      head_tag;
    logic [CNT_W-1:0]         occupancy;
    logic                     dropped;

    // Handshake control.
    sspq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Entry cells and result register.
    sspq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS),
        .CNT_W         (CNT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .command       (s_tuser),
        .priority_req  (s_tdata[PRIORITY_BITS-1:0]),
        .tag           (s_tdata[PRIORITY_BITS+TAG_BITS-1:PRIORITY_BITS]),
        .valid_res     (valid_res),
        .head_priority (head_priority),
        .head_tag      (head_tag),
        .occupancy     (occupancy),
        .dropped       (dropped)
    );

    // Output word packing.
    assign m_tdata = OUT_DW'({dropped, occupancy, head_tag, head_priority});
    assign m_tuser = valid_res;

endmodule

/* rtl/core/sspq_checker.sv */
// Port-level checks for the stable sorted priority queue, bound to the top.
// Depends only on the top level's ports and parameters.
`timescale 1ns / 1ps

module sspq_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 8
) (
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((PRIORITY_BITS + TAG_BITS + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0]
                m_tdata,
    input logic m_tuser
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_LO = PRIORITY_BITS + TAG_BITS;
    localparam int DROP_B = OCC_LO + CNT_W;

    logic [CNT_W-1:0] occ;
    logic             drop;

    assign occ  = m_tdata[DROP_B-1:OCC_LO];
    assign drop = m_tdata[DROP_B];

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The count never exceeds the capacity.
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above capacity");

    // An empty pop reports all zeros.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty pop with nonzero fields");

    // Overflow is only reported with the queue full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && drop |-> occ == CNT_W'(QUEUE_DEPTH) && m_tuser)
        else $error("dropped flag without a full queue");

endmodule

bind stable_sorted_priority_queue_core sspq_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
) u_sspq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/stable_sorted_priority_queue_core_tb.sv */
// Self-checking testbench for stable_sorted_priority_queue_core: random push and pop words
// under random input gaps and output stalls, checked against an in-bench queue predictor.
// Depends on sspq_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_core_tb;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TAG_BITS      = 8;
    localparam int OCC_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_DATA_W      = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_DATA_W      = ((PRIORITY_BITS + TAG_BITS + OCC_BITS + 1 + 7) / 8) * 8;
    localparam int RANDOM_WORDS  = 1700;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    // One result word, split into its fields.
    typedef struct packed {
        logic                     valid_res;
        logic [PRIORITY_BITS-1:0] head_priority;
        logic [TAG_BITS-1:0]      head_tag;
        logic [OCC_BITS-1:0]      occupancy;
        logic                     dropped;
    } head_report_t;

    // Queue predictor plus the list of head reports still owed by the core.
    class sspq_scoreboard;
        logic [PRIORITY_BITS-1:0] held_prio[QUEUE_DEPTH];
        logic [TAG_BITS-1:0]      held_tag[QUEUE_DEPTH];
        int                       held_count;
        head_report_t             owed_reports[$];
        int                       errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        // Insert behind every entry of greater or equal priority, so ties keep arrival order.
        function void insert_sorted(logic [PRIORITY_BITS-1:0] prio, logic [TAG_BITS-1:0] tg);
            int pos;
            pos = 0;
            while (pos < held_count && held_prio[pos] >= prio)
                pos++;
            for (int i = held_count; i > pos; i--)
            begin
                held_prio[i] = held_prio[i-1];
                held_tag[i]  = held_tag[i-1];
            end
            held_prio[pos] = prio;
            held_tag[pos]  = tg;
            held_count++;
        endfunction

        // Apply one accepted input word and queue the head report it must produce.
        function void note_word(logic cmd, logic [PRIORITY_BITS-1:0] prio,
                                logic [TAG_BITS-1:0] tg);
            head_report_t rep;
            rep = '0;
            if (cmd == sspq_pkg::CMD_PUSH)
            begin
                if (held_count < QUEUE_DEPTH)
                    insert_sorted(prio, tg);
                else
                begin
                    // Full: the new entry either displaces the tail or is lost itself.
                    rep.dropped = 1'b1;
                    if (prio > held_prio[QUEUE_DEPTH-1])
                    begin
                        held_count = QUEUE_DEPTH - 1;
                        insert_sorted(prio, tg);
                    end
                end
                rep.valid_res     = 1'b1;
                rep.head_priority = held_prio[0];
                rep.head_tag      = held_tag[0];
            end
            else if (held_count > 0)
            begin
                rep.valid_res     = 1'b1;
                rep.head_priority = held_prio[0];
                rep.head_tag      = held_tag[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_prio[i-1] = held_prio[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
            end
            rep.occupancy = OCC_BITS'(held_count);
            owed_reports.push_back(rep);
        endfunction

        // Compare one output word with the oldest owed report.
        function void check_result(head_report_t got);
            head_report_t want;
            if (owed_reports.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: output word %h with no result pending", $realtime, got);
                return;
            end
            want = owed_reports.pop_front();
            if (got.valid_res !== want.valid_res || got.head_priority !== want.head_priority ||
                got.head_tag !== want.head_tag || got.occupancy !== want.occupancy ||
                got.dropped !== want.dropped)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch valid/prio/tag/occ/drop ",
                              "exp %b/%0d/%0d/%0d/%b got %b/%0d/%0d/%0d/%b"},
                             $realtime, want.valid_res, want.head_priority, want.head_tag,
                             want.occupancy, want.dropped, got.valid_res, got.head_priority,
                             got.head_tag, got.occupancy, got.dropped);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // [7:0] priority_req, [15:8] tag
    logic [S_DATA_W-1:0] s_tdata;
    // [0] command
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // [7:0] head_priority, [15:8] head_tag, [20:16] occupancy, [21] dropped
    logic [M_DATA_W-1:0] m_tdata;
    // [0] valid_res
    logic                m_tuser;

    sspq_scoreboard book;
    int             burst_left;
    int             cycle_count;

    stable_sorted_priority_queue_core #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one word, sometimes inserting an idle gap between bursts, and wait for the handshake.
    task automatic send_word(input logic cmd, input logic [PRIORITY_BITS-1:0] prio,
                             input logic [TAG_BITS-1:0] tg);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({tg, prio});
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.note_word(cmd, prio, tg);
    endtask

    // Receiver stall pattern: always ready, random, periodic, or mostly stalled.
    initial
    begin
        int mode;
        int mode_left;
        int period;
        int on_cycles;
        int phase;
        m_tready  = 1'b0;
        mode_left = 0;
        mode      = 0;
        period    = 1;
        on_cycles = 1;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
                period    = $urandom_range(2, 8);
                on_cycles = $urandom_range(1, period - 1);
            end
            mode_left--;
            phase++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ((phase % period) < on_cycles);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        head_report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid_res     = m_tuser;
            got.head_priority = m_tdata[PRIORITY_BITS-1:0];
            got.head_tag      = m_tdata[PRIORITY_BITS +: TAG_BITS];
            got.occupancy     = m_tdata[PRIORITY_BITS + TAG_BITS +: OCC_BITS];
            got.dropped       = m_tdata[PRIORITY_BITS + TAG_BITS + OCC_BITS];
            book.check_result(got);
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Reset, directed words, random words, drain and verdict.
    initial
    begin
        int                       push_pct;
        int                       prio_mode;
        logic [PRIORITY_BITS-1:0] prio_base;
        logic                     cmd;
        logic [PRIORITY_BITS-1:0] prio;
        logic [TAG_BITS-1:0]      tg;

        book       = new();
        burst_left = 0;
        push_pct   = 50;
        prio_mode  = 0;
        prio_base  = '0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = sspq_pkg::CMD_PUSH;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pop on an empty queue, then field extremes and a tie at the top priority.
        send_word(sspq_pkg::CMD_POP, 8'hFF, 8'hFF);
        send_word(sspq_pkg::CMD_PUSH, 8'h00, 8'h00);
        send_word(sspq_pkg::CMD_PUSH, 8'hFF, 8'hFF);
        send_word(sspq_pkg::CMD_PUSH, 8'hFF, 8'h01);
        send_word(sspq_pkg::CMD_POP, 8'h00, 8'h00);
        // Fill to capacity; equal priorities must stay in arrival order.
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
            send_word(sspq_pkg::CMD_PUSH, (i % 2 == 0) ? 8'h55 : 8'hAA, 8'(8'h10 + i));
        // Full: a tie with the tail is lost, a higher priority displaces the tail.
        send_word(sspq_pkg::CMD_PUSH, 8'h00, 8'hAA);
        send_word(sspq_pkg::CMD_PUSH, 8'hC8, 8'h55);
        send_word(sspq_pkg::CMD_POP, 8'h00, 8'h00);

        // Random phases alternate between filling, draining and churning the queue.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    2:       push_pct = 75;
                    default: push_pct = 92;
                endcase
                prio_mode = $urandom_range(0, 2);
                prio_base = PRIORITY_BITS'($urandom_range(0, 252));
            end
            cmd = ($urandom_range(1, 100) <= push_pct) ? sspq_pkg::CMD_PUSH : sspq_pkg::CMD_POP;
            case (prio_mode)
                // Narrow band: many equal priorities exercise tie ordering.
                1:       prio = prio_base + PRIORITY_BITS'($urandom_range(0, 3));
                2:       prio = ($urandom_range(0, 2) == 0) ? PRIORITY_BITS'($urandom) :
                                (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
                default: prio = PRIORITY_BITS'($urandom);
            endcase
            tg = TAG_BITS'($urandom);
            send_word(cmd, prio, tg);
        end
        s_tvalid <= 1'b0;

        // Wait for every owed result, then watch for stray words before the verdict.
        while (book.owed_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.errors == 0 && book.owed_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
